[rtl/core/spims_pkg.sv]
`default_nettype none
package spims_pkg;

	localparam int WORD_BITS   = 8;
	localparam int BITS_W      = $clog2(WORD_BITS + 1);
	localparam int TICK_W      = 16;
	localparam int RX_W        = 8;
	localparam int TX_W        = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_POLARITY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PHASE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_ACTIVE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_ENABLE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD        = 3'd5;

	localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd100;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [TX_W-1:0] tx_byte;
		logic            last_byte;
		logic            release_select;
		logic            miso_level;
	} item_t;

endpackage
`default_nettype wire

[rtl/core/spims_front.sv]
`default_nettype none
module spims_front import spims_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire logic            func,
	input  wire logic [TX_W-1:0] tx_byte,
	input  wire logic            last_byte,
	input  wire logic            release_select,
	input  wire logic            miso_level,
	output logic                 push,
	output item_t                push_item,
	input  wire logic            full
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign push      = valid_s1 && !full;
	assign req_stall = valid_s1 && full;
	assign take      = req_valid && !req_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify the request
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op             <= func ? OP_TICK : OP_LOAD;
			item_s1.tx_byte        <= tx_byte;
			item_s1.last_byte      <= last_byte;
			item_s1.release_select <= release_select;
			item_s1.miso_level     <= miso_level;
		end
	end

endmodule
`default_nettype wire

[rtl/core/spims_queue.sv]
`default_nettype none
module spims_queue import spims_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       empty
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

endmodule
`default_nettype wire

[rtl/core/spims_back.sv]
`default_nettype none
module spims_back import spims_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  empty,
	input  wire item_t                 pop_item,
	output logic                       pop,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       sck_level,
	output logic                       mosi_level,
	output logic                       select_level,
	output logic [RX_W-1:0]            rx_byte,
	output logic                       rx_valid,
	output logic                       busy_res
);

	logic              cpol_q;
	logic              cpha_q;
	logic              lsb_first_q;
	logic              sel_high_q;
	logic              sel_en_q;
	logic [TICK_W-1:0] half_period_q;

	logic [WORD_BITS-1:0] shift_word_q;
	logic [BITS_W-1:0]    bits_left_q;
	logic [TICK_W-1:0]    tick_count_q;
	logic                 second_half_q;
	logic                 sel_asserted_q;
	logic                 clock_level_q;
	logic                 data_level_q;
	logic                 final_pending_q;
	logic                 release_pending_q;
	logic                 res_valid_q;

	logic [WORD_BITS-1:0] shift_word_d;
	logic [BITS_W-1:0]    bits_left_d;
	logic [TICK_W-1:0]    tick_count_d;
	logic                 second_half_d;
	logic                 sel_asserted_d;
	logic                 clock_level_d;
	logic                 data_level_d;
	logic                 final_pending_d;
	logic                 release_pending_d;
	logic [RX_W-1:0]      rx_d;
	logic                 rx_valid_d;

	logic [TICK_W-1:0]    hp;
	logic [TICK_W-1:0]    tick_inc;
	logic [BITS_W-1:0]    bits_dec;
	logic [WORD_BITS-1:0] load_word;
	logic [WORD_BITS-1:0] sample_word;
	logic                 idle_sck;

	assign pop       = !empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpol_q        <= 1'b0;
			cpha_q        <= 1'b0;
			lsb_first_q   <= 1'b0;
			sel_high_q    <= 1'b0;
			sel_en_q      <= 1'b1;
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOCK_POLARITY:     cpol_q        <= cfg_data[0];
				REG_CLOCK_PHASE:        cpha_q        <= cfg_data[0];
				REG_LSB_FIRST:          lsb_first_q   <= cfg_data[0];
				REG_SELECT_ACTIVE_HIGH: sel_high_q    <= cfg_data[0];
				REG_SELECT_ENABLE:      sel_en_q      <= cfg_data[0];
				REG_HALF_PERIOD:        half_period_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign hp        = (half_period_q == '0) ? TICK_W'(1) : half_period_q;
	assign tick_inc  = tick_count_q + TICK_W'(1);
	assign bits_dec  = bits_left_q - BITS_W'(1);
	assign idle_sck  = cpol_q;
	assign load_word = WORD_BITS'(pop_item.tx_byte);
	assign sample_word = lsb_first_q
		? ((shift_word_q >> 1) | (WORD_BITS'(pop_item.miso_level) << (WORD_BITS - 1)))
		: ((shift_word_q << 1) | WORD_BITS'(pop_item.miso_level));

	always_comb begin
		shift_word_d      = shift_word_q;
		bits_left_d       = bits_left_q;
		tick_count_d      = tick_count_q;
		second_half_d     = second_half_q;
		sel_asserted_d    = sel_asserted_q;
		clock_level_d     = clock_level_q;
		data_level_d      = data_level_q;
		final_pending_d   = final_pending_q;
		release_pending_d = release_pending_q;
		rx_d              = '0;
		rx_valid_d        = 1'b0;
		case (pop_item.op)
			OP_LOAD: begin
				if (bits_left_q == '0) begin
					shift_word_d      = load_word;
					bits_left_d       = BITS_W'(WORD_BITS);
					tick_count_d      = '0;
					second_half_d     = 1'b0;
					final_pending_d   = pop_item.last_byte;
					release_pending_d = pop_item.release_select;
					sel_asserted_d    = 1'b1;
					clock_level_d     = cpha_q ? !idle_sck : idle_sck;
					data_level_d      = lsb_first_q ? load_word[0] : load_word[WORD_BITS-1];
				end
			end
			OP_TICK: begin
				if (bits_left_q != '0) begin
					tick_count_d = tick_inc;
					if (tick_inc >= hp) begin
						tick_count_d = '0;
						if (!second_half_q) begin
							// sampling edge
							clock_level_d = cpha_q ? idle_sck : !idle_sck;
							shift_word_d  = sample_word;
							if (bits_left_q == BITS_W'(1)) begin
								rx_valid_d = 1'b1;
								rx_d       = RX_W'(sample_word);
							end
							second_half_d = 1'b1;
						end else begin
							second_half_d = 1'b0;
							bits_left_d   = bits_dec;
							if (!cpha_q) begin
								clock_level_d = idle_sck;
							end
							if (bits_dec != '0) begin
								data_level_d = lsb_first_q ? shift_word_q[0]
									: shift_word_q[WORD_BITS-1];
								if (cpha_q) begin
									clock_level_d = !idle_sck;
								end
							end else if (final_pending_q && release_pending_q) begin
								sel_asserted_d = 1'b0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q      <= '0;
			bits_left_q       <= '0;
			tick_count_q      <= '0;
			second_half_q     <= 1'b0;
			sel_asserted_q    <= 1'b0;
			clock_level_q     <= 1'b0;
			data_level_q      <= 1'b0;
			final_pending_q   <= 1'b0;
			release_pending_q <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				shift_word_q      <= shift_word_d;
				bits_left_q       <= bits_left_d;
				tick_count_q      <= tick_count_d;
				second_half_q     <= second_half_d;
				sel_asserted_q    <= sel_asserted_d;
				clock_level_q     <= clock_level_d;
				data_level_q      <= data_level_d;
				final_pending_q   <= final_pending_d;
				release_pending_q <= release_pending_d;
				res_valid_q       <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sck_level    <= clock_level_d;
			mosi_level   <= data_level_d;
			select_level <= sel_en_q && (sel_asserted_d ^ !sel_high_q);
			rx_byte      <= rx_d;
			rx_valid     <= rx_valid_d;
			busy_res     <= bits_left_d != '0;
		end
	end

	a_rx_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && rx_valid |-> busy_res)
		else $error("received word reported while not busy");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= BITS_W'(WORD_BITS))
		else $error("bit count out of range");

	a_idle_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q == '0 |-> !second_half_q)
		else $error("half phase left set while idle");

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_valid_q)
		else $error("result lost after pop");

endmodule
`default_nettype wire

[rtl/core/spi_master_shifter_core.sv]
`default_nettype none
// channel    handshake              payload
// request    req_valid / req_stall  func, tx_byte, last_byte, release_select, miso_level
// result     res_valid / res_stall  sck_level, mosi_level, select_level, rx_byte,
//                                   rx_valid, busy_res
// config     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle sustained unless req_stall or res_stall holds the flow; a result
// passes front register (at the accepting edge), queue, back state update with result register
// the back unit updates the shifter state once per cycle while its result is not stalled, which sets the rate
// reset clears the shifter state and loads register defaults, no clearing pass
// a stalled result holds the back unit; the queue absorbs up to 4 requests meanwhile
module spi_master_shifter_core import spims_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic                  func,
	input  wire logic [TX_W-1:0]       tx_byte,
	input  wire logic                  last_byte,
	input  wire logic                  release_select,
	input  wire logic                  miso_level,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic                       sck_level,
	output logic                       mosi_level,
	output logic                       select_level,
	output logic [RX_W-1:0]            rx_byte,
	output logic                       rx_valid,
	output logic                       busy_res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	item_t pop_item;
	logic  empty;
	logic  cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	spims_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.func           (func),
		.tx_byte        (tx_byte),
		.last_byte      (last_byte),
		.release_select (release_select),
		.miso_level     (miso_level),
		.push           (push),
		.push_item      (push_item),
		.full           (full)
	);

	spims_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	spims_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.empty        (empty),
		.pop_item     (pop_item),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.sck_level    (sck_level),
		.mosi_level   (mosi_level),
		.select_level (select_level),
		.rx_byte      (rx_byte),
		.rx_valid     (rx_valid),
		.busy_res     (busy_res)
	);

endmodule
`default_nettype wire

[test/spi_master_shifter_core_test.sv]
`timescale 1ns / 100ps

module spi_master_shifter_core_test;
	import spims_pkg::*;

	localparam int IDLE_PCT   = 21;
	localparam int RAND_ITEMS = 950;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 80;

	typedef struct packed {
		logic            sck;
		logic            mosi;
		logic            sel;
		logic [RX_W-1:0] rx;
		logic            rxv;
		logic            busy;
	} pins_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic func = 1'b1;
	logic [TX_W-1:0] tx_byte = '0;
	logic last_byte = 1'b0;
	logic release_select = 1'b0;
	logic miso_level = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic sck_level;
	logic mosi_level;
	logic select_level;
	logic [RX_W-1:0] rx_byte;
	logic rx_valid;
	logic busy_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	spi_master_shifter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.tx_byte(tx_byte),
		.last_byte(last_byte),
		.release_select(release_select),
		.miso_level(miso_level),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sck_level(sck_level),
		.mosi_level(mosi_level),
		.select_level(select_level),
		.rx_byte(rx_byte),
		.rx_valid(rx_valid),
		.busy_res(busy_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register copies
	logic cfg_cpol = 1'b0;
	logic cfg_cpha = 1'b0;
	logic cfg_lsb = 1'b0;
	logic cfg_sel_high = 1'b0;
	logic cfg_sel_en = 1'b1;
	logic [CFG_DATA_W-1:0] cfg_half = HALF_PERIOD_RESET;

	// shifter state
	logic [WORD_BITS-1:0] sh_word = '0;
	logic [BITS_W-1:0] bits_todo = '0;
	int unsigned tick_cnt = 0;
	logic late_half = 1'b0;
	logic cs_on = 1'b0;
	logic sck_q = 1'b0;
	logic mosi_q = 1'b0;
	logic last_pend = 1'b0;
	logic rel_pend = 1'b0;

	item_t pending[$];
	pins_t pin_q[$];
	pins_t want;

	int req_cnt = 0;
	int res_cnt = 0;
	int word_cnt = 0;
	int wr_cnt = 0;
	int err_cnt = 0;
	int rand_items = 0;
	int hold_cnt = 0;
	bit held = 1'b0;
	bit req_taken = 1'b0;

	wire calm = req_cnt >= 550 && req_cnt < 700;

	function automatic logic lead_bit();
		return cfg_lsb ? sh_word[0] : sh_word[WORD_BITS-1];
	endfunction

	task automatic spi_advance(input item_t it);
		pins_t p;
		logic idle_sck;
		int unsigned hp;
		p = '0;
		idle_sck = cfg_cpol;
		if (it.op == OP_LOAD) begin
			if (bits_todo == 0) begin
				sh_word = WORD_BITS'(it.tx_byte);
				bits_todo = BITS_W'(WORD_BITS);
				tick_cnt = 0;
				late_half = 1'b0;
				last_pend = it.last_byte;
				rel_pend = it.release_select;
				cs_on = 1'b1;
				sck_q = cfg_cpha ? !idle_sck : idle_sck;
				mosi_q = lead_bit();
			end
		end else if (bits_todo != 0) begin
			hp = (cfg_half == 0) ? 1 : cfg_half;
			tick_cnt++;
			if (tick_cnt >= hp) begin
				tick_cnt = 0;
				if (!late_half) begin
					sck_q = cfg_cpha ? idle_sck : !idle_sck;
					if (cfg_lsb)
						sh_word = {it.miso_level, sh_word[WORD_BITS-1:1]};
					else
						sh_word = {sh_word[WORD_BITS-2:0], it.miso_level};
					if (bits_todo == 1) begin
						p.rxv = 1'b1;
						p.rx = RX_W'(sh_word);
					end
					late_half = 1'b1;
				end else begin
					late_half = 1'b0;
					bits_todo--;
					if (!cfg_cpha)
						sck_q = idle_sck;
					if (bits_todo != 0) begin
						mosi_q = lead_bit();
						if (cfg_cpha)
							sck_q = !idle_sck;
					end else if (last_pend && rel_pend) begin
						cs_on = 1'b0;
					end
				end
			end
		end
		p.sck = sck_q;
		p.mosi = mosi_q;
		p.sel = cfg_sel_en ? (cs_on ^ !cfg_sel_high) : 1'b0;
		p.busy = bits_todo != 0;
		pin_q.push_back(p);
	endtask

	task automatic check_field(input string what, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
		end
	endtask

	// request side
	always @(negedge clk) begin
		item_t nxt;
		if (!req_valid || req_taken) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending.pop_front();
				func <= nxt.op;
				tx_byte <= nxt.tx_byte;
				last_byte <= nxt.last_byte;
				release_select <= nxt.release_select;
				miso_level <= nxt.miso_level;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side stall, with one long hold-off
	always @(negedge clk) begin
		if (!held && req_cnt >= HOLD_AT) begin
			hold_cnt = HOLD_LEN;
			held = 1'b1;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				spi_advance(item_t'{op_t'(func), tx_byte, last_byte, release_select, miso_level});
				req_taken = 1'b1;
				req_cnt++;
			end
			if (res_valid && !res_stall) begin
				if (pin_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with nothing expected, actual rx %0h", $time, rx_byte);
				end else begin
					want = pin_q.pop_front();
					check_field("sck_level", want.sck, sck_level);
					check_field("mosi_level", want.mosi, mosi_level);
					check_field("select_level", want.sel, select_level);
					check_field("rx_byte", want.rx, rx_byte);
					check_field("rx_valid", want.rxv, rx_valid);
					check_field("busy_res", want.busy, busy_res);
					res_cnt++;
					if (want.rxv)
						word_cnt++;
				end
			end
		end
	end

	task automatic drain();
		while (pending.size() != 0 || req_valid || pin_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CLOCK_POLARITY: cfg_cpol = val[0];
			REG_CLOCK_PHASE: cfg_cpha = val[0];
			REG_LSB_FIRST: cfg_lsb = val[0];
			REG_SELECT_ACTIVE_HIGH: cfg_sel_high = val[0];
			REG_SELECT_ENABLE: cfg_sel_en = val[0];
			REG_HALF_PERIOD: cfg_half = val[CFG_DATA_W-1:0];
			default: ;
		endcase
		wr_cnt++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input logic cpol, input logic cpha, input logic lsb,
			input logic sel_high, input logic sel_en, input int unsigned hp);
		drain();
		write_reg(REG_CLOCK_POLARITY, cpol);
		write_reg(REG_CLOCK_PHASE, cpha);
		write_reg(REG_LSB_FIRST, lsb);
		write_reg(REG_SELECT_ACTIVE_HIGH, sel_high);
		write_reg(REG_SELECT_ENABLE, sel_en);
		write_reg(REG_HALF_PERIOD, hp);
	endtask

	function automatic item_t any_item();
		item_t it;
		it.op = op_t'($urandom_range(1));
		it.tx_byte = TX_W'($urandom);
		it.last_byte = 1'($urandom_range(1));
		it.release_select = 1'($urandom_range(1));
		it.miso_level = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic queue_item(input item_t it);
		pending.push_back(it);
		rand_items++;
	endtask

	initial begin
		item_t it;
		int unsigned hp;
		int unsigned r;
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: tick while idle, load, load while busy, tick
		pending.push_back('{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1});
		pending.push_back('{OP_LOAD, 8'hFF, 1'b1, 1'b1, 1'b0});
		pending.push_back('{OP_LOAD, 8'h00, 1'b0, 1'b0, 1'b1});
		pending.push_back('{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1});

		// zero half period, mode 3, lsb first, no select line
		set_mode(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 0);
		repeat (16) pending.push_back('{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1});
		pending.push_back('{OP_LOAD, 8'h00, 1'b0, 1'b0, 1'b0});
		repeat (2) pending.push_back('{OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0});

		// longest half period
		set_mode(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF);
		repeat (3) pending.push_back('{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1});

		while (rand_items < RAND_ITEMS) begin
			r = $urandom_range(11);
			hp = (r == 0) ? 16'hFFFF : (r < 3) ? $urandom_range(4, 12) : $urandom_range(1, 3);
			set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), hp);
			repeat ($urandom_range(2, 6)) begin
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(1, 6)) queue_item(any_item());
				end else begin
					it = any_item();
					it.op = OP_LOAD;
					queue_item(it);
					n = (hp > 12) ? int'($urandom_range(10, 40))
						: int'(2 * WORD_BITS * hp + $urandom_range(0, 3));
					repeat (n) begin
						it = any_item();
						if ($urandom_range(24) != 0)
							it.op = OP_TICK;
						queue_item(it);
					end
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("checked %0d results over %0d requests, %0d words received",
			res_cnt, req_cnt, word_cnt);
		$display("%0d register writes across all clock modes and select settings", wr_cnt);
		if (err_cnt == 0)
			$display("spi_master_shifter_core_test passed");
		else
			$display("spi_master_shifter_core_test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pin_q.size());
		$display("spi_master_shifter_core_test failed");
		$finish;
	end

endmodule
